FILE: hdl/mdas_pkg.sv
// shared constants, codes and controller/datapath interface types for the
// multidimensional array store; no dependencies
package mdas_pkg;

   localparam int FIELD_DIMS        = 4;
   localparam int MAX_DIMS          = 4;
   localparam int DIM_IDX_W         = $clog2(FIELD_DIMS);
   localparam int INDEX_W           = 12;
   localparam int SIZE_W            = 13;
   localparam int STRIDE_W          = 13;
   localparam int NDIM_W            = 3;
   localparam int VALUE_W           = 32;
   localparam int STATUS_W          = 2;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 13;
   localparam int DEF_STORE_DEPTH   = 4096;
   localparam int DEF_ELEM_WIDTH    = 32;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_NUM_DIMS  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_DIM0 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_DIM1 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_DIM2 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_DIM3 = 3'd4;

   // reset values of the shape registers
   localparam logic [NDIM_W-1:0] RST_NUM_DIMS  = 3'd1;
   localparam logic [SIZE_W-1:0] RST_SIZE_DIM0 = 13'd4096;
   localparam logic [SIZE_W-1:0] RST_SIZE_REST = 13'd1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHAPE = 2'd2;

   typedef struct packed {
      logic                 clear_step;
      logic                 derive_init;
      logic                 derive_step;
      logic                 capture;
      logic                 mac_init;
      logic                 mac_step;
      logic                 mem_access;
      logic                 respond;
      logic [DIM_IDX_W-1:0] dim;
   } mdas_cmd_type;

   typedef struct packed {
      logic                 clear_last;
      logic                 shape_ok;
      logic                 index_ok;
      logic [DIM_IDX_W-1:0] last_dim;
   } mdas_stat_type;

endpackage

FILE: hdl/mdas_ctrl.sv
// sequencer for clearing, stride derivation and element access
// depends on mdas_pkg
module mdas_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    csr_we,
   input  mdas_pkg::mdas_stat_type stat,
   output mdas_pkg::mdas_cmd_type  cmd,
   output logic                    busy
);
   import mdas_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DINIT,
      ST_DSTEP,
      ST_CHECK,
      ST_MAC,
      ST_MEM,
      ST_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [DIM_IDX_W-1:0] step_ff, step_in;
   logic                 pend_ff, pend_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      pend_in  = pend_ff | csr_we;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // a pending shape change is folded in before any access
            if (pend_ff) begin
               state_in = ST_DINIT;
            end else if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_DINIT: begin
            cmd.derive_init = 1'b1;
            pend_in         = csr_we;
            step_in         = stat.last_dim;
            state_in        = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.derive_step = 1'b1;
            cmd.dim         = step_ff;
            if (step_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_CHECK: begin
            cmd.mac_init = 1'b1;
            step_in      = '0;
            if (stat.shape_ok && stat.index_ok) begin
               state_in = ST_MAC;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_MAC: begin
            cmd.mac_step = 1'b1;
            cmd.dim      = step_ff;
            if (step_ff == stat.last_dim) begin
               state_in = ST_MEM;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_MEM: begin
            cmd.mem_access = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE) || pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
         pend_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

FILE: hdl/mdas_datapath.sv
// shape registers, stride derivation, offset multiply-add, element memory
// and result registers; depends on mdas_pkg
module mdas_datapath #(
   parameter int STORE_DEPTH = mdas_pkg::DEF_STORE_DEPTH,
   parameter int ELEM_WIDTH  = mdas_pkg::DEF_ELEM_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mdas_pkg::mdas_cmd_type              cmd,
   output mdas_pkg::mdas_stat_type             stat,
   input  logic                                csr_we,
   input  logic [mdas_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [mdas_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_opcode,
   input  logic [mdas_pkg::INDEX_W-1:0]        req_index0,
   input  logic [mdas_pkg::INDEX_W-1:0]        req_index1,
   input  logic [mdas_pkg::INDEX_W-1:0]        req_index2,
   input  logic [mdas_pkg::INDEX_W-1:0]        req_index3,
   input  logic signed [mdas_pkg::VALUE_W-1:0] req_write_value,
   output logic                                rsp_strobe,
   output logic signed [mdas_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [mdas_pkg::STATUS_W-1:0]       rsp_status
);
   import mdas_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   // running extent product saturates one above the capacity
   localparam int PROD_W = $clog2(STORE_DEPTH + 2);
   localparam int MUL_W  = PROD_W + SIZE_W;
   localparam int MAC_W  = INDEX_W + STRIDE_W + 1;

   // shape registers and derived strides
   logic [NDIM_W-1:0]   num_dims_ff;
   logic [SIZE_W-1:0]   size_ff [FIELD_DIMS];
   logic [STRIDE_W-1:0] stride_ff [FIELD_DIMS];
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic                nz_ff;
   logic [MUL_W-1:0]    prod_mul;
   logic [NDIM_W-1:0]   n_use;

   // captured request
   logic                      op_ff;
   logic [INDEX_W-1:0]        idx_ff [FIELD_DIMS];
   logic signed [VALUE_W-1:0] wval_ff;

   // offset accumulation and memory
   logic [ADDR_W-1:0]     acc_ff;
   logic [MAC_W-1:0]      mac_sum;
   logic [ADDR_W-1:0]     clear_addr_ff;
   logic [ELEM_WIDTH-1:0] mem [STORE_DEPTH];
   logic [ELEM_WIDTH-1:0] rd_data_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_addr;
   logic [ELEM_WIDTH-1:0] mem_wdata;

   // result registers
   logic                      rsp_strobe_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic                      index_bad;

   always_comb begin
      n_use = num_dims_ff;
      if (n_use == '0) begin
         n_use = NDIM_W'(1);
      end
      if (n_use > NDIM_W'(MAX_DIMS)) begin
         n_use = NDIM_W'(MAX_DIMS);
      end
      if (n_use > NDIM_W'(FIELD_DIMS)) begin
         n_use = NDIM_W'(FIELD_DIMS);
      end
   end

   always_comb begin
      index_bad = 1'b0;
      for (int d = 0; d < FIELD_DIMS; d++) begin
         if ((d < int'(n_use)) && ({1'b0, idx_ff[d]} >= size_ff[d])) begin
            index_bad = 1'b1;
         end
      end
   end

   assign stat.clear_last = (clear_addr_ff == ADDR_W'(STORE_DEPTH - 1));
   assign stat.shape_ok   = nz_ff && (prod_ff <= PROD_W'(STORE_DEPTH));
   assign stat.index_ok   = !index_bad;
   assign stat.last_dim   = DIM_IDX_W'(n_use - 1'b1);

   // stride of a dimension is the product of the extents inside it
   assign prod_mul = MUL_W'(prod_ff) * MUL_W'(size_ff[cmd.dim]);

   always_comb begin
      if (prod_mul > MUL_W'(STORE_DEPTH)) begin
         prod_in = PROD_W'(STORE_DEPTH + 1);
      end else begin
         prod_in = PROD_W'(prod_mul);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= RST_NUM_DIMS;
         size_ff[0]  <= RST_SIZE_DIM0;
         size_ff[1]  <= RST_SIZE_REST;
         size_ff[2]  <= RST_SIZE_REST;
         size_ff[3]  <= RST_SIZE_REST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_NUM_DIMS:  num_dims_ff <= csr_data[NDIM_W-1:0];
            REG_SIZE_DIM0: size_ff[0]  <= csr_data[SIZE_W-1:0];
            REG_SIZE_DIM1: size_ff[1]  <= csr_data[SIZE_W-1:0];
            REG_SIZE_DIM2: size_ff[2]  <= csr_data[SIZE_W-1:0];
            REG_SIZE_DIM3: size_ff[3]  <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.derive_init) begin
         for (int d = 0; d < FIELD_DIMS; d++) begin
            stride_ff[d] <= '0;
         end
         prod_ff <= PROD_W'(1);
         nz_ff   <= 1'b1;
      end else if (cmd.derive_step) begin
         stride_ff[cmd.dim] <= STRIDE_W'(prod_ff);
         prod_ff            <= prod_in;
         if (size_ff[cmd.dim] == '0) begin
            nz_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_opcode;
         idx_ff[0] <= req_index0;
         idx_ff[1] <= req_index1;
         idx_ff[2] <= req_index2;
         idx_ff[3] <= req_index3;
         wval_ff   <= req_write_value;
      end
   end

   // one index times stride per beat of the accumulator
   assign mac_sum = MAC_W'(acc_ff)
                  + MAC_W'(idx_ff[cmd.dim]) * MAC_W'(stride_ff[cmd.dim]);

   always_ff @(posedge clock) begin
      if (cmd.mac_init) begin
         acc_ff <= '0;
      end else if (cmd.mac_step) begin
         acc_ff <= ADDR_W'(mac_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   assign mem_we    = cmd.clear_step || (cmd.mem_access && op_ff);
   assign mem_addr  = cmd.clear_step ? clear_addr_ff : acc_ff;
   assign mem_wdata = cmd.clear_step ? '0 : ELEM_WIDTH'($signed(wval_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_access) begin
         rd_data_ff <= mem[acc_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         if (!stat.shape_ok) begin
            rsp_status_ff <= STATUS_SHAPE;
            rsp_value_ff  <= '0;
         end else if (index_bad) begin
            rsp_status_ff <= STATUS_RANGE;
            rsp_value_ff  <= '0;
         end else begin
            rsp_status_ff <= STATUS_OK;
            rsp_value_ff  <= op_ff ? '0 : VALUE_W'($signed(rd_data_ff));
         end
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

FILE: hdl/multidim_array_store_unit.sv
// Row-major store for an array of one to four dimensions. After reset the
// block clears its STORE_DEPTH elements, one per cycle, and then derives the
// strides, holding busy high throughout. A register write raises busy while
// the strides are derived again. An item is taken when start is high and
// busy low; a valid access then occupies the block through a check, one
// pass of the shared multiply-add per dimension in use, a memory access and
// a response before the next accept, while an out-of-range index or bad
// shape goes from the check straight to the response. Each result shows for
// one cycle on rsp_strobe and cannot be held off. Top level; depends on
// mdas_pkg, mdas_ctrl and mdas_datapath.
module multidim_array_store_unit #(
   parameter int STORE_DEPTH = mdas_pkg::DEF_STORE_DEPTH,
   parameter int ELEM_WIDTH  = mdas_pkg::DEF_ELEM_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [mdas_pkg::INDEX_W-1:0]        req_index0,
   input  logic [mdas_pkg::INDEX_W-1:0]        req_index1,
   input  logic [mdas_pkg::INDEX_W-1:0]        req_index2,
   input  logic [mdas_pkg::INDEX_W-1:0]        req_index3,
   input  logic signed [mdas_pkg::VALUE_W-1:0] req_write_value,
   output logic                                rsp_strobe,
   output logic signed [mdas_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [mdas_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mdas_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [mdas_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mdas_pkg::*;

   mdas_cmd_type  cmd;
   mdas_stat_type stat;
   logic          csr_we;

   // register writes are always taken; deriving is repeated after a write during it
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   mdas_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .csr_we (csr_we),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   mdas_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .ELEM_WIDTH  (ELEM_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_opcode      (req_opcode),
      .req_index0      (req_index0),
      .req_index1      (req_index1),
      .req_index2      (req_index2),
      .req_index3      (req_index3),
      .req_write_value (req_write_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status)
   );

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_strobe_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without an item in flight");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_read_value == '0))
      else $error("error result carries nonzero data");

endmodule

FILE: dv/multidim_array_store_unit_test.sv
`timescale 1ns / 1ps
// self-checking testbench for multidim_array_store_unit: queued accesses and shape
// writes, a mirror of the array and its strides, per-field compare of every result;
// depends on mdas_pkg and the block's rtl only
module multidim_array_store_unit_test;
   import mdas_pkg::*;

   localparam logic OP_READ        = 1'b0;
   localparam logic OP_WRITE       = 1'b1;
   localparam int   WATCHDOG_LIMIT = 20000;
   localparam int   ACCESS_TARGET  = 800;
   localparam int   MIRROR_AW      = $clog2(DEF_STORE_DEPTH);

   typedef enum logic [1:0] {BEAT_ACCESS, BEAT_CSR, BEAT_DRAIN} beat_kind_type;

   typedef struct packed {
      beat_kind_type                      kind;
      logic                               opcode;
      logic [FIELD_DIMS-1:0][INDEX_W-1:0] index;
      logic signed [VALUE_W-1:0]          wdata;
      logic [CSR_ADDR_W-1:0]              csr_idx;
      logic [CSR_DATA_W-1:0]              csr_val;
   } array_beat_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [STATUS_W-1:0]       status;
   } array_reply_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_opcode = OP_READ;
   logic [INDEX_W-1:0]        req_index0 = '0;
   logic [INDEX_W-1:0]        req_index1 = '0;
   logic [INDEX_W-1:0]        req_index2 = '0;
   logic [INDEX_W-1:0]        req_index3 = '0;
   logic signed [VALUE_W-1:0] req_write_value = '0;
   logic                      rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_ADDR_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   multidim_array_store_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_index0      (req_index0),
      .req_index1      (req_index1),
      .req_index2      (req_index2),
      .req_index3      (req_index3),
      .req_write_value (req_write_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #2 clock = ~clock;

   // mirror of the block: element array, shape registers and derived strides
   logic [VALUE_W-1:0]  elem_mirror [DEF_STORE_DEPTH];
   logic [NDIM_W-1:0]   ndims_reg;
   logic [SIZE_W-1:0]   extent [FIELD_DIMS];
   logic [STRIDE_W-1:0] stride [FIELD_DIMS];

   array_beat_type  beat_q [$];
   array_reply_type array_reply_q [$];
   array_beat_type  cur_beat;
   int              gap_left = 0;
   int              burst_left = 0;
   int              idle_cycles = 0;
   int              mismatches = 0;

   // shape the stimulus generator is currently planning against
   int           plan_n;
   logic [SIZE_W-1:0] plan_ext [FIELD_DIMS];

   function automatic int dims_used();
      int n;
      n = ndims_reg;
      if (n == 0) n = 1;
      if (n > MAX_DIMS) n = MAX_DIMS;
      if (n > FIELD_DIMS) n = FIELD_DIMS;
      return n;
   endfunction

   function automatic void rederive_strides();
      longint unsigned run;
      int              i;
      run = 1;
      for (i = 0; i < FIELD_DIMS; i++) stride[i] = '0;
      for (i = dims_used() - 1; i >= 0; i--) begin
         stride[i] = run[STRIDE_W-1:0];
         run = run * extent[i];
      end
   endfunction

   function automatic void apply_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_NUM_DIMS:  ndims_reg = val[NDIM_W-1:0];
         REG_SIZE_DIM0: extent[0] = val;
         REG_SIZE_DIM1: extent[1] = val;
         REG_SIZE_DIM2: extent[2] = val;
         REG_SIZE_DIM3: extent[3] = val;
         default: return;
      endcase
      rederive_strides();
   endfunction

   function automatic void compute_array_reply(array_beat_type b);
      array_reply_type       r;
      longint unsigned       prod;
      longint unsigned       off;
      logic [MIRROR_AW-1:0]  addr;
      int                    i;
      bit                    bad_shape;
      bit                    bad_index;
      r = '0;
      prod = 1;
      bad_shape = 1'b0;
      bad_index = 1'b0;
      off = 0;
      for (i = 0; i < dims_used(); i++) begin
         if (extent[i] == 0) bad_shape = 1'b1;
         prod = prod * extent[i];
      end
      if (bad_shape || prod > DEF_STORE_DEPTH) begin
         r.status = STATUS_SHAPE;
      end else begin
         for (i = 0; i < dims_used(); i++) begin
            if (b.index[i] >= extent[i]) bad_index = 1'b1;
            else off = off + b.index[i] * stride[i];
         end
         addr = MIRROR_AW'(off % DEF_STORE_DEPTH);
         if (bad_index) begin
            r.status = STATUS_RANGE;
         end else begin
            r.status = STATUS_OK;
            if (b.opcode == OP_WRITE) elem_mirror[addr] = b.wdata;
            else r.value = elem_mirror[addr];
         end
      end
      array_reply_q.push_back(r);
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_access(logic op, logic [INDEX_W-1:0] i0,
                                        logic [INDEX_W-1:0] i1, logic [INDEX_W-1:0] i2,
                                        logic [INDEX_W-1:0] i3, logic signed [VALUE_W-1:0] wv);
      array_beat_type b;
      b = '0;
      b.kind = BEAT_ACCESS;
      b.opcode = op;
      b.index = {i3, i2, i1, i0};
      b.wdata = wv;
      beat_q.push_back(b);
   endfunction

   function automatic void queue_drain();
      array_beat_type b;
      b = '0;
      b.kind = BEAT_DRAIN;
      beat_q.push_back(b);
   endfunction

   function automatic void queue_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      array_beat_type b;
      b = '0;
      b.kind = BEAT_CSR;
      b.csr_idx = idx;
      b.csr_val = val;
      beat_q.push_back(b);
   endfunction

   // register writes only once every outstanding access has answered
   function automatic void queue_shape(logic [CSR_DATA_W-1:0] nd, logic [SIZE_W-1:0] s0,
                                       logic [SIZE_W-1:0] s1, logic [SIZE_W-1:0] s2,
                                       logic [SIZE_W-1:0] s3);
      queue_drain();
      queue_csr(REG_NUM_DIMS, nd);
      queue_csr(REG_SIZE_DIM0, s0);
      queue_csr(REG_SIZE_DIM1, s1);
      queue_csr(REG_SIZE_DIM2, s2);
      queue_csr(REG_SIZE_DIM3, s3);
      plan_n = (nd[NDIM_W-1:0] == 0) ? 1 :
               ((nd[NDIM_W-1:0] > MAX_DIMS) ? MAX_DIMS : nd[NDIM_W-1:0]);
      plan_ext[0] = s0;
      plan_ext[1] = s1;
      plan_ext[2] = s2;
      plan_ext[3] = s3;
   endfunction

   function automatic bit queue_random_shape();
      logic [NDIM_W-1:0]     nd_raw;
      logic [CSR_DATA_W-1:0] nd_word;
      logic [SIZE_W-1:0]     ext [FIELD_DIMS];
      int                    n;
      int                    budget;
      int                    i;
      int                    r;
      bit                    broken;
      nd_raw = NDIM_W'($urandom_range(0, 7));
      n = (nd_raw == 0) ? 1 : ((nd_raw > MAX_DIMS) ? MAX_DIMS : nd_raw);
      budget = DEF_STORE_DEPTH;
      broken = 1'b0;
      for (i = 0; i < FIELD_DIMS; i++) begin
         if (i < n) begin
            r = $urandom_range(0, 99);
            if (r < 70) ext[i] = SIZE_W'($urandom_range(1, (budget < 12) ? budget : 12));
            else if (r < 90) ext[i] = SIZE_W'($urandom_range(1, budget));
            else ext[i] = SIZE_W'(budget);
            budget = budget / ext[i];
         end else begin
            ext[i] = SIZE_W'($urandom_range(0, 8191));
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         i = $urandom_range(0, n - 1);
         ext[i] = $urandom_range(0, 1) ? '0
                                       : SIZE_W'($urandom_range(DEF_STORE_DEPTH + 1, 8191));
         broken = 1'b1;
      end
      // upper bits of the dimension count word are don't-care
      nd_word = CSR_DATA_W'($urandom());
      nd_word[NDIM_W-1:0] = nd_raw;
      queue_shape(nd_word, ext[0], ext[1], ext[2], ext[3]);
      return broken;
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index(logic [SIZE_W-1:0] ext);
      int r;
      r = $urandom_range(0, 99);
      if (r < 92 && ext != 0)
         return INDEX_W'($urandom_range(0, (ext > 4096) ? 4095 : ext - 1));
      if (r < 96) return INDEX_W'($urandom());
      return (ext > 4095) ? 12'd4095 : ext[INDEX_W-1:0];
   endfunction

   function automatic void queue_random_access();
      logic [INDEX_W-1:0]        idx [FIELD_DIMS];
      logic signed [VALUE_W-1:0] wv;
      int                        i;
      int                        r;
      for (i = 0; i < FIELD_DIMS; i++)
         idx[i] = (i < plan_n) ? pick_index(plan_ext[i]) : INDEX_W'($urandom());
      r = $urandom_range(0, 99);
      if (r < 5) wv = 32'sh8000_0000;
      else if (r < 10) wv = 32'sh7FFF_FFFF;
      else wv = $urandom();
      queue_access($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                   idx[0], idx[1], idx[2], idx[3], wv);
   endfunction

   // driver: one beat presented at a time, access or register write
   always @(posedge clock) begin : drive_beats
      logic           nxt_start;
      logic           nxt_csr_valid;
      logic           free;
      array_beat_type b;
      nxt_start = start;
      nxt_csr_valid = csr_valid;
      free = 1'b0;
      if (reset) begin
         nxt_start = 1'b0;
         nxt_csr_valid = 1'b0;
      end else begin
         if (start && !busy) begin
            compute_array_reply(cur_beat);
            nxt_start = 1'b0;
            free = 1'b1;
            gap_left = pick_gap();
         end else if (csr_valid && csr_ready) begin
            apply_csr(cur_beat.csr_idx, cur_beat.csr_val);
            nxt_csr_valid = 1'b0;
            free = 1'b1;
            gap_left = pick_gap();
         end else if (!start && !csr_valid) begin
            free = 1'b1;
         end
         if (free) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (beat_q.size() != 0) begin
               b = beat_q[0];
               case (b.kind)
                  BEAT_DRAIN: begin
                     if (array_reply_q.size() == 0) b = beat_q.pop_front();
                  end
                  BEAT_CSR: begin
                     cur_beat = beat_q.pop_front();
                     csr_index <= b.csr_idx;
                     csr_data <= b.csr_val;
                     nxt_csr_valid = 1'b1;
                  end
                  default: begin
                     cur_beat = beat_q.pop_front();
                     req_opcode <= b.opcode;
                     req_index0 <= b.index[0];
                     req_index1 <= b.index[1];
                     req_index2 <= b.index[2];
                     req_index3 <= b.index[3];
                     req_write_value <= b.wdata;
                     nxt_start = 1'b1;
                  end
               endcase
            end
         end
      end
      start <= nxt_start;
      csr_valid <= nxt_csr_valid;
   end

   always @(posedge clock) begin : check_replies
      array_reply_type want;
      if (!reset && rsp_strobe) begin
         if (array_reply_q.size() == 0) begin
            $error("unexpected result: read_value %0d status %0d", rsp_read_value, rsp_status);
            mismatches++;
         end else begin
            want = array_reply_q.pop_front();
            if (rsp_read_value !== want.value) begin
               $error("read_value: expected %0d, got %0d", want.value, rsp_read_value);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((start && !busy) || (csr_valid && csr_ready) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("multidim_array_store_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int accesses;
      int count;
      int k;
      int i;
      bit broken;

      for (i = 0; i < DEF_STORE_DEPTH; i++) elem_mirror[i] = '0;
      ndims_reg = RST_NUM_DIMS;
      extent[0] = RST_SIZE_DIM0;
      for (i = 1; i < FIELD_DIMS; i++) extent[i] = RST_SIZE_REST;
      rederive_strides();

      // reset shape: one dimension of 4096, unused indexes all ones
      queue_access(OP_READ, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'sd5);
      queue_access(OP_WRITE, 12'd4095, 12'd0, 12'd0, 12'd0, 32'sh8000_0000);
      queue_access(OP_WRITE, 12'd0, 12'd4095, 12'd4095, 12'd4095, 32'sh7FFF_FFFF);
      queue_access(OP_READ, 12'd4095, 12'd0, 12'd0, 12'd0, 32'sd0);
      queue_access(OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 32'sd0);

      // dimension count above four acts as four
      queue_shape(13'd7, 13'd4, 13'd8, 13'd16, 13'd8);
      queue_access(OP_WRITE, 12'd3, 12'd7, 12'd15, 12'd7, -32'sd1);
      queue_access(OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 32'sd0);
      queue_access(OP_READ, 12'd3, 12'd7, 12'd15, 12'd7, 32'sd0);
      queue_access(OP_WRITE, 12'd4, 12'd0, 12'd0, 12'd0, 32'sd9);
      queue_access(OP_READ, 12'd0, 12'd0, 12'd0, 12'd8, 32'sd0);
      queue_access(OP_READ, 12'd0, 12'd4095, 12'd0, 12'd0, 32'sd0);

      // zero dimension count acts as one
      queue_shape(13'd0, 13'd1, 13'd8191, 13'd8191, 13'd8191);
      queue_access(OP_READ, 12'd0, 12'd2730, 12'd1365, 12'd4095, 32'sd0);
      queue_access(OP_WRITE, 12'd1, 12'd0, 12'd0, 12'd0, 32'sd3);

      // zero extent, oversized extent, product over capacity
      queue_shape(13'd2, 13'd0, 13'd1, 13'd1, 13'd1);
      queue_access(OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 32'sd0);
      queue_shape(13'd3, 13'd8191, 13'd1, 13'd1, 13'd1);
      queue_access(OP_WRITE, 12'd0, 12'd0, 12'd0, 12'd0, 32'sd77);
      queue_access(OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 32'sd0);
      queue_shape(13'd4, 13'd64, 13'd65, 13'd1, 13'd1);
      queue_access(OP_WRITE, 12'd0, 12'd0, 12'd0, 12'd0, 32'sd77);

      // writes to unmapped register indexes change nothing
      queue_drain();
      for (k = REG_SIZE_DIM3 + 1; k < (1 << CSR_ADDR_W); k++)
         queue_csr(CSR_ADDR_W'(k), CSR_DATA_W'($urandom()));
      queue_shape(13'd2, 13'd4096, 13'd1, 13'd1, 13'd1);
      queue_access(OP_READ, 12'd4095, 12'd0, 12'd0, 12'd0, 32'sd0);
      queue_access(OP_READ, 12'd0, 12'd1, 12'd0, 12'd0, 32'sd0);
      queue_shape(13'd4, 13'd1, 13'd1, 13'd1, 13'd4096);
      queue_access(OP_WRITE, 12'd0, 12'd0, 12'd0, 12'd4095, 32'sh5A5A_A5A5);
      queue_access(OP_READ, 12'd0, 12'd0, 12'd0, 12'd4095, 32'sd0);

      accesses = 0;
      while (accesses < ACCESS_TARGET) begin
         broken = queue_random_shape();
         count = broken ? $urandom_range(3, 8) : $urandom_range(20, 100);
         for (k = 0; k < count; k++) begin
            queue_random_access();
            // sender holds off until the block has answered everything
            if ($urandom_range(0, 99) < 4) queue_drain();
         end
         accesses += count;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (beat_q.size() != 0 || start || csr_valid || array_reply_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (array_reply_q.size() != 0) begin
         $error("%0d results never arrived", array_reply_q.size());
         mismatches++;
      end
      if (mismatches == 0) $display("multidim_array_store_unit test passed");
      else $display("multidim_array_store_unit test failed");
      $finish;
   end

endmodule
